// ===== sv/nnsag_pkg.sv =====
// shared types, constants and helpers for the nearest-neighbour scale address generator
package nnsag_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int EXT_W      = COORD_BITS + 1;
  localparam int STEP_W     = EXT_W + FRAC_BITS;
  localparam int ACC_W      = STEP_W + 1;
  localparam int REM_W      = EXT_W + 1;
  localparam int CNT_W      = $clog2(STEP_W + 1);
  localparam int IDX_W      = 3;

  localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(1) << COORD_BITS;
  localparam logic [ACC_W-1:0] ONE_FIX = ACC_W'(1) << FRAC_BITS;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_SRC_LEFT   = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC_TOP    = 3'd1;
  localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_DST_LEFT   = 3'd4;
  localparam logic [IDX_W-1:0] REG_DST_TOP    = 3'd5;
  localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 3'd6;
  localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 3'd7;

  typedef struct packed {
    logic [COORD_BITS-1:0] src_left;
    logic [COORD_BITS-1:0] src_top;
    logic [EXT_W-1:0]      dst_width;
    logic [EXT_W-1:0]      dst_height;
    logic [COORD_BITS-1:0] dst_left;
    logic [COORD_BITS-1:0] dst_top;
  } walk_cfg_t;

  typedef struct packed {
    logic fire;
    logic start;
    logic kill;
    logic load_col;
    logic load_row;
  } walk_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic             valid_res;
    logic [EXT_W-1:0] src_col;
    logic [EXT_W-1:0] src_row;
    logic [EXT_W-1:0] dst_col;
    logic [EXT_W-1:0] dst_row;
    logic             end_of_row;
    logic             end_of_blit;
  } pix_res_t;

  function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] v);
    logic [EXT_W-1:0] r;
    r = v;
    if (v == '0) r = EXT_W'(1);
    else if (v > MAX_EXT) r = MAX_EXT;
    return r;
  endfunction

endpackage

// ===== sv/nnsag_div.sv =====
// shared restoring divider, one quotient bit per cycle
module nnsag_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [nnsag_pkg::STEP_W-1:0] dividend,
  input  logic [nnsag_pkg::EXT_W-1:0]  divisor,
  output logic [nnsag_pkg::STEP_W-1:0] quotient,
  output nnsag_pkg::div_stat_t         stat
);
  import nnsag_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem;
  logic [STEP_W-1:0] q;
  logic [EXT_W-1:0] dvs;
  logic [REM_W-1:0] trial;
  logic             take;

  assign trial = {rem[REM_W-2:0], q[STEP_W-1]};
  assign take  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEP_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= take ? trial - {1'b0, dvs} : trial;
      q   <= {q[STEP_W-2:0], take};
    end
  end

  assign quotient  = q;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== sv/nnsag_walk.sv =====
// step registers, fixed-point accumulators and pixel walk for one result per step
module nnsag_walk (
  input  logic                         clk,
  input  logic                         rst,
  input  nnsag_pkg::walk_ctl_t         ctl,
  input  nnsag_pkg::walk_cfg_t         cfg,
  input  logic [nnsag_pkg::STEP_W-1:0] step_val,
  output nnsag_pkg::pix_res_t          res
);
  import nnsag_pkg::*;

  logic [STEP_W-1:0] col_step;
  logic [STEP_W-1:0] row_step;
  logic [ACC_W-1:0]  col_accum;
  logic [ACC_W-1:0]  row_accum;
  logic [EXT_W-1:0]  src_col_offset;
  logic [EXT_W-1:0]  src_row_offset;
  logic [EXT_W-1:0]  dst_col_offset;
  logic [EXT_W-1:0]  dst_row_offset;
  logic              busy;

  logic [ACC_W-1:0]  ca0, ra0, ca1, ra1, ca2;
  logic [EXT_W-1:0]  sco0, sro0, dco0, dro0, sco1, sro1, sco2;
  logic [EXT_W:0]    sro_sum, sco_sum;
  logic [EXT_W-1:0]  dw_last, dh_last;
  logic              active, new_row, eor, eob;

  always_comb begin
    active = ctl.start | busy;
    if (ctl.start) begin
      ca0  = ONE_FIX;
      ra0  = ONE_FIX;
      sco0 = '0;
      sro0 = '0;
      dco0 = '0;
      dro0 = '0;
    end else begin
      ca0  = col_accum;
      ra0  = row_accum;
      sco0 = src_col_offset;
      sro0 = src_row_offset;
      dco0 = dst_col_offset;
      dro0 = dst_row_offset;
    end

    // a new destination row pulls source rows and restarts the column walk
    new_row = dco0 == '0;
    sro_sum = {1'b0, sro0} + ra0[ACC_W-1:FRAC_BITS];
    if (new_row) begin
      sro1 = sro_sum[EXT_W-1:0];
      ra1  = ACC_W'(ra0[FRAC_BITS-1:0]) + ACC_W'(row_step);
      ca1  = ONE_FIX;
      sco1 = '0;
    end else begin
      sro1 = sro0;
      ra1  = ra0;
      ca1  = ca0;
      sco1 = sco0;
    end
    sco_sum = {1'b0, sco1} + ca1[ACC_W-1:FRAC_BITS];
    sco2    = sco_sum[EXT_W-1:0];
    ca2     = ACC_W'(ca1[FRAC_BITS-1:0]) + ACC_W'(col_step);

    dw_last = clamp_ext(cfg.dst_width) - EXT_W'(1);
    dh_last = clamp_ext(cfg.dst_height) - EXT_W'(1);
    eor     = dco0 >= dw_last;
    eob     = eor && (dro0 >= dh_last);

    res = '0;
    if (active) begin
      res.valid_res   = 1'b1;
      res.src_col     = EXT_W'(cfg.src_left) + sco2 - EXT_W'(1);
      res.src_row     = EXT_W'(cfg.src_top) + sro1 - EXT_W'(1);
      res.dst_col     = EXT_W'(cfg.dst_left) + dco0;
      res.dst_row     = EXT_W'(cfg.dst_top) + dro0;
      res.end_of_row  = eor;
      res.end_of_blit = eob;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_step       <= '0;
      row_step       <= '0;
      col_accum      <= '0;
      row_accum      <= '0;
      src_col_offset <= '0;
      src_row_offset <= '0;
      dst_col_offset <= '0;
      dst_row_offset <= '0;
      busy           <= 1'b0;
    end else begin
      if (ctl.load_col) col_step <= step_val;
      if (ctl.load_row) row_step <= step_val;
      if (ctl.kill) begin
        busy <= 1'b0;
      end else if (ctl.fire && active) begin
        col_accum      <= ca2;
        row_accum      <= ra1;
        src_col_offset <= sco2;
        src_row_offset <= sro1;
        if (eob) begin
          busy           <= 1'b0;
          dst_col_offset <= '0;
          dst_row_offset <= dro0;
        end else if (eor) begin
          busy           <= 1'b1;
          dst_col_offset <= '0;
          dst_row_offset <= dro0 + EXT_W'(1);
        end else begin
          busy           <= 1'b1;
          dst_col_offset <= dco0 + EXT_W'(1);
          dst_row_offset <= dro0;
        end
      end
    end
  end

endmodule

// ===== sv/nearest_neighbor_scale_address_gen_top.sv =====
// top level: configuration registers, start sequencer and result register
// A transaction with start_req = 0 returns the next pixel pair in the cycle after it is
// taken, and a new one can be taken every cycle while results are drained; when no blit
// is running it returns a result with every field 0. A transaction with start_req = 1
// runs the column step and then the row step through one shared restoring divider at one
// quotient bit per cycle; its result is loaded in S_FIRE, after both steps, and
// in_ready stays low meanwhile. A start with any extent register at 0 is dropped at once
// and returns the all-zero result. Configuration writes are always taken.
module nearest_neighbor_scale_address_gen_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [nnsag_pkg::IDX_W-1:0] cfg_index,
  input  logic [nnsag_pkg::EXT_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        start_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        valid_res,
  output logic [nnsag_pkg::EXT_W-1:0] src_col,
  output logic [nnsag_pkg::EXT_W-1:0] src_row,
  output logic [nnsag_pkg::EXT_W-1:0] dst_col,
  output logic [nnsag_pkg::EXT_W-1:0] dst_row,
  output logic                        end_of_row,
  output logic                        end_of_blit
);
  import nnsag_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DCOL = 2'd1;
  localparam logic [1:0] S_DROW = 2'd2;
  localparam logic [1:0] S_FIRE = 2'd3;

  logic [COORD_BITS-1:0] src_left, src_top, dst_left, dst_top;
  logic [EXT_W-1:0]      src_width, src_height, dst_width, dst_height;

  logic [1:0]        state, state_next;
  logic              in_fire, zero_ext, div_start, out_load;
  logic [STEP_W-1:0] dividend, quotient;
  logic [EXT_W-1:0]  divisor;
  div_stat_t         div_stat;
  walk_ctl_t         ctl;
  walk_cfg_t         wcfg;
  pix_res_t          walk_res, out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_left   <= '0;
      src_top    <= '0;
      src_width  <= EXT_W'(1);
      src_height <= EXT_W'(1);
      dst_left   <= '0;
      dst_top    <= '0;
      dst_width  <= EXT_W'(1);
      dst_height <= EXT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SRC_LEFT:   src_left   <= cfg_data[COORD_BITS-1:0];
        REG_SRC_TOP:    src_top    <= cfg_data[COORD_BITS-1:0];
        REG_SRC_WIDTH:  src_width  <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data;
        REG_DST_LEFT:   dst_left   <= cfg_data[COORD_BITS-1:0];
        REG_DST_TOP:    dst_top    <= cfg_data[COORD_BITS-1:0];
        REG_DST_WIDTH:  dst_width  <= cfg_data;
        REG_DST_HEIGHT: dst_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign wcfg.src_left   = src_left;
  assign wcfg.src_top    = src_top;
  assign wcfg.dst_width  = dst_width;
  assign wcfg.dst_height = dst_height;
  assign wcfg.dst_left   = dst_left;
  assign wcfg.dst_top    = dst_top;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign zero_ext = (src_width == '0) || (src_height == '0) ||
                    (dst_width == '0) || (dst_height == '0);

  // column step first, row step once the column quotient is out
  assign div_start = (in_fire && start_req && !zero_ext) ||
                     (state == S_DCOL && div_stat.done);
  assign dividend  = (state == S_DCOL) ?
                     {clamp_ext(src_height), {FRAC_BITS{1'b0}}} :
                     {clamp_ext(src_width), {FRAC_BITS{1'b0}}};
  assign divisor   = (state == S_DCOL) ? clamp_ext(dst_height) : clamp_ext(dst_width);

  always_comb begin
    ctl.fire     = (in_fire && !start_req) || (state == S_FIRE);
    ctl.start    = state == S_FIRE;
    ctl.kill     = in_fire && start_req && zero_ext;
    ctl.load_col = (state == S_DCOL) && div_stat.done;
    ctl.load_row = (state == S_DROW) && div_stat.done;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire && start_req && !zero_ext) state_next = S_DCOL;
      S_DCOL: if (div_stat.done) state_next = S_DROW;
      S_DROW: if (div_stat.done) state_next = S_FIRE;
      S_FIRE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  nnsag_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .stat     (div_stat)
  );

  nnsag_walk u_walk (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .cfg      (wcfg),
    .step_val (quotient),
    .res      (walk_res)
  );

  assign out_load = ctl.fire || ctl.kill;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_res <= ctl.kill ? '0 : walk_res;
  end

  assign valid_res   = out_res.valid_res;
  assign src_col     = out_res.src_col;
  assign src_row     = out_res.src_row;
  assign dst_col     = out_res.dst_col;
  assign dst_row     = out_res.dst_row;
  assign end_of_row  = out_res.end_of_row;
  assign end_of_blit = out_res.end_of_blit;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !out_load)
    else $error("result register overwritten while held");

  a_div_in_seq: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DCOL || state == S_DROW))
    else $error("divider finished outside the start sequence");

  a_ready_idle_div: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_stat.busy)
    else $error("input taken while divider busy");

  a_start_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIRE) |=> out_valid)
    else $error("start sequence ended without a result");

endmodule

// ===== bench/nearest_neighbor_scale_address_gen_top_tb.sv =====
// testbench for the nearest-neighbour scale address generator, checked against a predictor
module nearest_neighbor_scale_address_gen_top_tb;
  import nnsag_pkg::*;

  localparam int CYCLE_LIMIT = 600_000;
  localparam int TARGET_ITEMS = 1050;
  localparam int NUM_REGS = 1 << IDX_W;
  localparam int IDLE_PCT = 21;

  // predicts the pixel pair for every accepted transaction and checks results in order
  class blit_tracker;
    logic [EXT_W-1:0]  regs [NUM_REGS];
    logic [STEP_W-1:0] h_step, v_step;
    logic [ACC_W-1:0]  h_pos, v_pos;
    logic [EXT_W-1:0]  src_x, src_y, dst_x, dst_y;
    bit                walking;
    pix_res_t          expected_pixels [$];
    int                errors;
    int                results_seen;

    function new();
      foreach (regs[i]) regs[i] = '0;
      regs[REG_SRC_WIDTH]  = EXT_W'(1);
      regs[REG_SRC_HEIGHT] = EXT_W'(1);
      regs[REG_DST_WIDTH]  = EXT_W'(1);
      regs[REG_DST_HEIGHT] = EXT_W'(1);
      h_step = '0;
      v_step = '0;
      h_pos = '0;
      v_pos = '0;
      src_x = '0;
      src_y = '0;
      dst_x = '0;
      dst_y = '0;
      walking = 1'b0;
      errors = 0;
      results_seen = 0;
    endfunction

    function logic [EXT_W-1:0] fit_extent(logic [EXT_W-1:0] v);
      if (v == '0) return EXT_W'(1);
      if (v > EXT_W'(1 << COORD_BITS)) return EXT_W'(1 << COORD_BITS);
      return v;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [EXT_W-1:0] data);
      case (idx)
        REG_SRC_LEFT, REG_SRC_TOP, REG_DST_LEFT, REG_DST_TOP: begin
          regs[idx] = {1'b0, data[COORD_BITS-1:0]};
        end
        default: begin
          regs[idx] = data;
        end
      endcase
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void note(logic start);
      pix_res_t         px;
      logic [EXT_W-1:0] dw, dh;
      bit               row_done, blit_done;
      px = '0;
      if (start) begin
        if (regs[REG_SRC_WIDTH] == '0 || regs[REG_SRC_HEIGHT] == '0 ||
            regs[REG_DST_WIDTH] == '0 || regs[REG_DST_HEIGHT] == '0) begin
          // start with an empty rectangle is dropped
          walking = 1'b0;
          expected_pixels.push_back(px);
          return;
        end
        h_step = (STEP_W'(fit_extent(regs[REG_SRC_WIDTH])) << FRAC_BITS) /
                 fit_extent(regs[REG_DST_WIDTH]);
        v_step = (STEP_W'(fit_extent(regs[REG_SRC_HEIGHT])) << FRAC_BITS) /
                 fit_extent(regs[REG_DST_HEIGHT]);
        h_pos = ONE_FIX;
        v_pos = ONE_FIX;
        src_x = '0;
        src_y = '0;
        dst_x = '0;
        dst_y = '0;
        walking = 1'b1;
      end
      if (!walking) begin
        expected_pixels.push_back(px);
        return;
      end
      if (dst_x == '0) begin
        src_y = EXT_W'(src_y + (v_pos >> FRAC_BITS));
        v_pos = ACC_W'(v_pos[FRAC_BITS-1:0]) + v_step;
        h_pos = ONE_FIX;
        src_x = '0;
      end
      src_x = EXT_W'(src_x + (h_pos >> FRAC_BITS));
      h_pos = ACC_W'(h_pos[FRAC_BITS-1:0]) + h_step;

      // row and blit ends follow the live destination extents
      dw = fit_extent(regs[REG_DST_WIDTH]);
      dh = fit_extent(regs[REG_DST_HEIGHT]);
      row_done = dst_x >= dw - 1'b1;
      blit_done = row_done && (dst_y >= dh - 1'b1);

      px.valid_res = 1'b1;
      px.src_col = regs[REG_SRC_LEFT] + src_x - 1'b1;
      px.src_row = regs[REG_SRC_TOP] + src_y - 1'b1;
      px.dst_col = regs[REG_DST_LEFT] + dst_x;
      px.dst_row = regs[REG_DST_TOP] + dst_y;
      px.end_of_row = row_done;
      px.end_of_blit = blit_done;
      expected_pixels.push_back(px);

      if (blit_done) begin
        walking = 1'b0;
        dst_x = '0;
      end else if (row_done) begin
        dst_x = '0;
        dst_y = dst_y + 1'b1;
      end else begin
        dst_x = dst_x + 1'b1;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    task compare(string field, logic [EXT_W-1:0] got, logic [EXT_W-1:0] want);
      if (got !== want) report($sformatf("%s got %0d expected %0d", field, got, want));
    endtask

    task check(pix_res_t got);
      pix_res_t want;
      results_seen++;
      if (expected_pixels.size() == 0) begin
        report("result with no transaction waiting");
        return;
      end
      want = expected_pixels.pop_front();
      compare("valid_res", got.valid_res, want.valid_res);
      compare("src_col", got.src_col, want.src_col);
      compare("src_row", got.src_row, want.src_row);
      compare("dst_col", got.dst_col, want.dst_col);
      compare("dst_row", got.dst_row, want.dst_row);
      compare("end_of_row", got.end_of_row, want.end_of_row);
      compare("end_of_blit", got.end_of_blit, want.end_of_blit);
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [EXT_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             start_req = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             valid_res;
  logic [EXT_W-1:0] src_col, src_row, dst_col, dst_row;
  logic             end_of_row, end_of_blit;

  blit_tracker tracker;
  int          items_sent = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;

  nearest_neighbor_scale_address_gen_top DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("nearest_neighbor_scale_address_gen_top_tb failed");
      $finish;
    end
  end

  // one process notes inputs before checking results, so a result cannot race its input
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) tracker.note(start_req);
      if (out_valid && out_ready) begin
        tracker.check(pix_res_t'{valid_res, src_col, src_row, dst_col, dst_row,
                                 end_of_row, end_of_blit});
      end
    end
  end

  always @(negedge clk) out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);

  task automatic send_item(input logic start);
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    start_req <= start;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [EXT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // every transaction returns one result, so an empty store means the block is idle
  task automatic finish_phase();
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.pending() != 0);
  endtask

  function automatic logic [EXT_W-1:0] pick_extent(bit dest);
    int r;
    r = $urandom_range(99);
    if (r < 2) return '0;
    if (r < 12) begin
      case ($urandom_range(3))
        0: return EXT_W'(1);
        1: return EXT_W'(4096);
        2: return EXT_W'(4097);
        default: return EXT_W'($urandom_range(4097, 8191));
      endcase
    end
    if (dest) return (r < 80) ? EXT_W'($urandom_range(1, 6)) : EXT_W'($urandom_range(7, 40));
    return (r < 60) ? EXT_W'($urandom_range(1, 16)) : EXT_W'($urandom_range(17, 8191));
  endfunction

  function automatic logic [EXT_W-1:0] pick_corner();
    int r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 30) return EXT_W'(4095);
    if (r < 40) return '1;
    return EXT_W'($urandom_range(0, 8191));
  endfunction

  task automatic random_phase();
    logic [IDX_W-1:0] idx;
    int               pixels, mode;
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = IDX_W'(i);
      if ($urandom_range(99) < 70) begin
        case (idx)
          REG_SRC_WIDTH, REG_SRC_HEIGHT: set_reg(idx, pick_extent(1'b0));
          REG_DST_WIDTH, REG_DST_HEIGHT: set_reg(idx, pick_extent(1'b1));
          default: set_reg(idx, pick_corner());
        endcase
      end
    end
    pixels = tracker.fit_extent(tracker.regs[REG_DST_WIDTH]) *
             tracker.fit_extent(tracker.regs[REG_DST_HEIGHT]);
    if (pixels > 60) pixels = $urandom_range(1, 60);
    mode = $urandom_range(99);
    if (mode < 78) begin
      // blit from its start, whole if at most 60 pixels, sometimes running on into idle
      send_item(1'b1);
      repeat (pixels - 1 + $urandom_range(0, 2)) send_item(1'b0);
    end else if (mode < 88) begin
      // carry on with whatever walk was left running
      repeat ($urandom_range(1, 20)) send_item(1'b0);
    end else begin
      repeat ($urandom_range(1, 15)) send_item($urandom_range(99) < 25);
    end
    finish_phase();
  endtask

  initial begin
    tracker = new();
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // idle advance, then a one pixel blit from the reset rectangle
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
    finish_phase();

    // corners at the top of the range so coordinates pass 4095, oversized source width
    set_reg(REG_SRC_LEFT, EXT_W'(4095));
    set_reg(REG_SRC_TOP, EXT_W'(4095));
    set_reg(REG_SRC_WIDTH, EXT_W'(8191));
    set_reg(REG_SRC_HEIGHT, EXT_W'(1));
    set_reg(REG_DST_LEFT, EXT_W'(4095));
    set_reg(REG_DST_TOP, EXT_W'(4095));
    set_reg(REG_DST_WIDTH, EXT_W'(3));
    set_reg(REG_DST_HEIGHT, EXT_W'(2));
    send_item(1'b1);
    repeat (6) send_item(1'b0);
    finish_phase();

    set_reg(REG_DST_WIDTH, '0);
    send_item(1'b1);
    send_item(1'b0);
    finish_phase();

    // largest destination and source height, restarted while the walk is still running
    set_reg(REG_SRC_WIDTH, EXT_W'(1));
    set_reg(REG_SRC_HEIGHT, EXT_W'(4096));
    set_reg(REG_DST_WIDTH, EXT_W'(4096));
    set_reg(REG_DST_HEIGHT, EXT_W'(4096));
    send_item(1'b1);
    repeat (3) send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
    finish_phase();

    // shrink the destination under a running walk
    set_reg(REG_DST_WIDTH, EXT_W'(2));
    send_item(1'b0);
    send_item(1'b0);
    finish_phase();

    set_reg(REG_SRC_WIDTH, '0);
    set_reg(REG_DST_HEIGHT, '0);
    send_item(1'b1);
    finish_phase();

    while (items_sent < TARGET_ITEMS) begin
      quiet <= (items_sent >= 400 && items_sent < 650);
      random_phase();
    end

    repeat (8) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("nearest_neighbor_scale_address_gen_top_tb passed");
    end else begin
      $display("nearest_neighbor_scale_address_gen_top_tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/nnsag_pkg.sv
sv/nnsag_div.sv
sv/nnsag_walk.sv
sv/nearest_neighbor_scale_address_gen_top.sv
bench/nearest_neighbor_scale_address_gen_top_tb.sv
